// File: rtl/efrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrc_pkg
// Shared constants and a CRC-32 word helper for the escaped frame receiver.
// ----------------------------------------------------------------------------
package efrc_pkg;

	localparam int MAX_PACKET_DEF = 256;

	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID = 2'd2;

	localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hA5;
	localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'h5A;
	localparam logic [BYTE_W-1:0] OWN_NODE_ID_RST = 8'h00;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// One 32-bit word, MSB first; unrolls to an XOR network.
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		for (int k = 0; k < 32; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/efrc_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrc_byte_if
// Valid/ready channel carrying one received raw byte.
// ----------------------------------------------------------------------------
interface efrc_byte_if import efrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/efrc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrc_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface efrc_cfg_if import efrc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/efrc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrc_result_if
// Valid/ready channel carrying a payload byte or an end-of-frame status.
// ----------------------------------------------------------------------------
interface efrc_result_if import efrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [BYTE_W-1:0] payload_byte;
	logic              crc_matches;
	logic              frame_accepted;
	logic [BYTE_W-1:0] frame_sender;
	logic [BYTE_W-1:0] frame_sequence;
	logic [BYTE_W-1:0] frame_length;

	modport source (
		output valid, output result_kind, output payload_byte, output crc_matches,
		output frame_accepted, output frame_sender, output frame_sequence,
		output frame_length, input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input crc_matches,
		input frame_accepted, input frame_sender, input frame_sequence,
		input frame_length, output ready
	);
endinterface

// File: rtl/escaped_frame_receiver_crc32_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc32_unit
// Byte-stuffed frame deframer: unescapes, parses header, emits payload bytes
// and a closing status with a CRC-32 check over the stored whole words.
// ----------------------------------------------------------------------------
// channel | dir | payload                                  | transfer when
// rx      | in  | rx_byte                                  | valid & ready
// cfg     | in  | index, data (0 start, 1 escape, 2 own id) | valid & ready
// res     | out | result_kind, payload_byte, status fields | valid & ready
//
// One byte per cycle while rx.ready is high; each byte updates the frame
// state and, at most, one result in the output register, in its transfer cycle.
// rx.ready is low only while a result waits and res.ready is low.
// The CRC word step is a 32-bit shift-and-XOR network in the accept cycle.
// arst_n clears the frame state and restores the register defaults; the
// result data registers are not reset and only matter while res.valid is high.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc32_unit import efrc_pkg::*; #(
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	efrc_byte_if.sink     rx,
	efrc_cfg_if.sink      cfg,
	efrc_result_if.source res
);

	localparam int STORED_W = $clog2(MAX_PACKET + 5);
	localparam int RAW_W    = $clog2(2 * (MAX_PACKET + 8) + 1);
	localparam int CMP_W    = ((STORED_W > 9) ? STORED_W : 9) + 1;
	localparam logic [STORED_W-1:0] STORED_LIMIT = STORED_W'(MAX_PACKET + 4);
	localparam logic [RAW_W-1:0]    RAW_LIMIT    = RAW_W'(2 * (MAX_PACKET + 8));

	logic [BYTE_W-1:0]   start_q, esc_byte_q, own_id_q;
	logic                in_frame_q, esc_pend_q, seq_seen_q;
	logic [BYTE_W-1:0]   length_q, sender_q, seq_q;
	logic [STORED_W-1:0] stored_q;
	logic [RAW_W-1:0]    raw_q;
	logic [2:0]          crc_taken_q;
	logic [31:0]         rcv_crc_q, run_crc_q;
	logic [23:0]         word_q;
	logic                out_valid_q;

	logic                in_frame_d, esc_pend_d, seq_seen_d;
	logic [BYTE_W-1:0]   length_d, sender_d, seq_d;
	logic [STORED_W-1:0] stored_d;
	logic [RAW_W-1:0]    raw_d;
	logic [2:0]          crc_taken_d;
	logic [31:0]         rcv_crc_d, run_crc_d;
	logic [23:0]         word_d;

	logic                emit, emit_status, crc_ok;
	logic                guard, do_store;
	logic [BYTE_W-1:0]   b;
	logic [31:0]         rcv_full;
	logic [CMP_W-1:0]    stored_x, len_x, taken_x;

	logic                kind_q, match_q, acc_q;
	logic [BYTE_W-1:0]   pay_q, snd_q, sq_q, len_q;

	logic rx_fire;

	assign rx.ready  = !out_valid_q || res.ready;
	assign rx_fire   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;
	assign b         = rx.rx_byte;

	always_comb begin
		guard = (raw_q >= RAW_LIMIT) || (stored_q >= STORED_LIMIT);

		in_frame_d  = guard ? 1'b0 : in_frame_q;
		length_d    = guard ? '0 : length_q;
		sender_d    = guard ? '0 : sender_q;
		seq_d       = guard ? '0 : seq_q;
		seq_seen_d  = guard ? 1'b0 : seq_seen_q;
		stored_d    = guard ? '0 : stored_q;
		raw_d       = guard ? '0 : raw_q;
		crc_taken_d = guard ? '0 : crc_taken_q;
		rcv_crc_d   = guard ? '0 : rcv_crc_q;
		run_crc_d   = guard ? CRC_INIT : run_crc_q;
		word_d      = guard ? '0 : word_q;

		raw_d       = raw_d + RAW_W'(1);
		esc_pend_d  = 1'b0;
		emit        = 1'b0;
		emit_status = 1'b0;
		do_store    = 1'b0;
		crc_ok      = 1'b0;

		stored_x = CMP_W'(stored_d);
		len_x    = CMP_W'(length_d);
		taken_x  = CMP_W'(crc_taken_d);

		rcv_full = rcv_crc_d;
		unique case (crc_taken_d[1:0])
			2'd0: rcv_full[31:24] = rcv_crc_d[31:24] | b;
			2'd1: rcv_full[23:16] = rcv_crc_d[23:16] | b;
			2'd2: rcv_full[15:8]  = rcv_crc_d[15:8] | b;
			2'd3: rcv_full[7:0]   = rcv_crc_d[7:0] | b;
			default: rcv_full = rcv_crc_d;
		endcase

		priority if (b == esc_byte_q && !esc_pend_q) begin
			esc_pend_d = 1'b1;
		end else if (!in_frame_d) begin
			if (b == start_q) begin
				in_frame_d = 1'b1;
				do_store   = 1'b1;
			end
		end else if (length_d == '0) begin
			length_d = b;
			do_store = 1'b1;
		end else if (sender_d == '0) begin
			sender_d = b;
			do_store = 1'b1;
		end else if (!seq_seen_d) begin
			seq_d      = b;
			seq_seen_d = 1'b1;
			do_store   = 1'b1;
		end else if (stored_x < len_x + CMP_W'(4)) begin
			do_store = 1'b1;
			emit     = 1'b1;
		end else if (stored_x + taken_x < len_x + CMP_W'(8)) begin
			rcv_crc_d   = rcv_full;
			crc_taken_d = crc_taken_d + 3'd1;
			if (crc_taken_d == 3'd4) begin
				emit        = 1'b1;
				emit_status = 1'b1;
				crc_ok      = (rcv_full == ~run_crc_d);
			end
		end

		if (do_store) begin
			unique case (stored_d[1:0])
				2'd0: word_d[7:0]   = word_d[7:0] | b;
				2'd1: word_d[15:8]  = word_d[15:8] | b;
				2'd2: word_d[23:16] = word_d[23:16] | b;
				2'd3: begin
					run_crc_d = crc_word(run_crc_d, {b, word_d});
					word_d    = '0;
				end
				default: word_d = word_d;
			endcase
			stored_d = stored_d + STORED_W'(1);
		end

		if (emit_status) begin
			in_frame_d  = 1'b0;
			length_d    = '0;
			sender_d    = '0;
			seq_d       = '0;
			seq_seen_d  = 1'b0;
			stored_d    = '0;
			raw_d       = '0;
			crc_taken_d = '0;
			rcv_crc_d   = '0;
			run_crc_d   = CRC_INIT;
			word_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_BYTE_RST;
			esc_byte_q  <= ESCAPE_BYTE_RST;
			own_id_q    <= OWN_NODE_ID_RST;
			in_frame_q  <= 1'b0;
			esc_pend_q  <= 1'b0;
			length_q    <= '0;
			sender_q    <= '0;
			seq_q       <= '0;
			seq_seen_q  <= 1'b0;
			stored_q    <= '0;
			raw_q       <= '0;
			crc_taken_q <= '0;
			rcv_crc_q   <= '0;
			run_crc_q   <= CRC_INIT;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_START_BYTE:  start_q    <= cfg.data;
					CFG_ESCAPE_BYTE: esc_byte_q <= cfg.data;
					CFG_OWN_NODE_ID: own_id_q   <= cfg.data;
					default: ;
				endcase
			end
			if (rx_fire) begin
				in_frame_q  <= in_frame_d;
				esc_pend_q  <= esc_pend_d;
				length_q    <= length_d;
				sender_q    <= sender_d;
				seq_q       <= seq_d;
				seq_seen_q  <= seq_seen_d;
				stored_q    <= stored_d;
				raw_q       <= raw_d;
				crc_taken_q <= crc_taken_d;
				rcv_crc_q   <= rcv_crc_d;
				run_crc_q   <= run_crc_d;
				word_q      <= word_d;
				out_valid_q <= emit;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && emit) begin
			kind_q  <= emit_status ? KIND_STATUS : KIND_PAYLOAD;
			pay_q   <= emit_status ? '0 : b;
			match_q <= crc_ok;
			acc_q   <= crc_ok && (sender_q != own_id_q);
			snd_q   <= emit_status ? sender_q : '0;
			sq_q    <= emit_status ? seq_q : '0;
			len_q   <= emit_status ? length_q : '0;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.result_kind    = kind_q;
	assign res.payload_byte   = pay_q;
	assign res.crc_matches    = match_q;
	assign res.frame_accepted = acc_q;
	assign res.frame_sender   = snd_q;
	assign res.frame_sequence = sq_q;
	assign res.frame_length   = len_q;

endmodule

// File: rtl/efrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrc_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module efrc_checker import efrc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rx_valid,
	input logic              rx_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic              result_kind,
	input logic [BYTE_W-1:0] payload_byte,
	input logic              crc_matches,
	input logic              frame_accepted,
	input logic [BYTE_W-1:0] frame_sender,
	input logic [BYTE_W-1:0] frame_sequence,
	input logic [BYTE_W-1:0] frame_length
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_kind) && $stable(payload_byte))
		else $error("result dropped or changed while stalled");

	a_rx_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || res_ready |-> rx_ready)
		else $error("input stalled with a free output register");

	a_res_from_rx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid && !res_ready) |-> $past(rx_valid && rx_ready))
		else $error("new result without an input transfer");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_PAYLOAD |-> !crc_matches && !frame_accepted
			&& frame_sender == '0 && frame_sequence == '0 && frame_length == '0)
		else $error("status fields set in a payload result");

	a_status_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KIND_STATUS |-> payload_byte == '0
			&& (!frame_accepted || crc_matches))
		else $error("status result inconsistent");

endmodule

bind escaped_frame_receiver_crc32_unit efrc_checker u_efrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_valid       (rx.valid),
	.rx_ready       (rx.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.result_kind    (res.result_kind),
	.payload_byte   (res.payload_byte),
	.crc_matches    (res.crc_matches),
	.frame_accepted (res.frame_accepted),
	.frame_sender   (res.frame_sender),
	.frame_sequence (res.frame_sequence),
	.frame_length   (res.frame_length)
);
